@@ hw/rtl/asns_pkg.sv @@
// Shared widths, register map and reset values for the adaptive snap smoother.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package asns_pkg;

  localparam int SAMPLE_W = 32;
  localparam int FRAC_W   = 16;
  localparam int GAIN_W   = 16;
  localparam int MAG_W    = SAMPLE_W + 1;
  localparam int SNAP_W   = 16;
  localparam int PROD_W   = MAG_W + SNAP_W;
  localparam int ONE_POS  = FRAC_W + 8;
  localparam int DIV_W    = ONE_POS + 1;
  localparam int CNT_W    = $clog2(SNAP_W + 1);

  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [ADDR_W-3:0] REG_SNAP_GAIN = '0;
  localparam logic [GAIN_W-1:0] GAIN_RESET    = GAIN_W'(256);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIFF  = 7'b0000010,
    ST_ABS   = 7'b0000100,
    ST_MULG  = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_MULS  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/asns_mul.sv @@
// Bit-serial shift-add multiplier: magnitude times a 16-bit operand, one bit a cycle.
// Depends on asns_pkg.
`timescale 1ns / 1ps
`default_nettype none
module asns_mul (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [asns_pkg::MAG_W-1:0]     a,
  input  wire logic [asns_pkg::SNAP_W-1:0]    b,
  output logic                                done,
  output logic      [asns_pkg::PROD_W-1:0]    prod
);

  logic [asns_pkg::MAG_W-1:0] a_reg;
  logic [asns_pkg::CNT_W-1:0] cnt;
  logic [asns_pkg::MAG_W:0]   sum;

  always_comb begin
    sum = {1'b0, prod[asns_pkg::PROD_W-1:asns_pkg::SNAP_W]}
        + (prod[0] ? {1'b0, a_reg} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= asns_pkg::CNT_W'(asns_pkg::SNAP_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == asns_pkg::CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      prod  <= {{asns_pkg::MAG_W{1'b0}}, b};
    end else if (cnt != '0) begin
      prod  <= {sum, prod[asns_pkg::SNAP_W-1:1]};
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/asns_div.sv @@
// Restoring divider for the snap curve: one quotient bit a cycle, 16 bits.
// Depends on asns_pkg.
`timescale 1ns / 1ps
`default_nettype none
module asns_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [asns_pkg::DIV_W-1:0]    num_hi,
  input  wire logic [asns_pkg::DIV_W-1:0]    den,
  output logic                               done,
  output logic      [asns_pkg::SNAP_W-1:0]   quot
);

  logic [asns_pkg::DIV_W-1:0] rem;
  logic [asns_pkg::DIV_W-1:0] den_reg;
  logic [asns_pkg::CNT_W-1:0] cnt;
  logic [asns_pkg::DIV_W:0]   trial;
  logic [asns_pkg::DIV_W:0]   shifted;

  always_comb begin
    shifted = {rem, 1'b0};
    trial   = shifted - {1'b0, den_reg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= asns_pkg::CNT_W'(asns_pkg::SNAP_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == asns_pkg::CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= num_hi;
      den_reg <= den;
      quot    <= '0;
    end else if (cnt != '0) begin
      if (!trial[asns_pkg::DIV_W]) begin
        rem  <= trial[asns_pkg::DIV_W-1:0];
        quot <= {quot[asns_pkg::SNAP_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[asns_pkg::DIV_W-1:0];
        quot <= {quot[asns_pkg::SNAP_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/adaptive_snap_smoother_top.sv @@
// Adaptive snap smoother: sequencer, serial multiplier and divider, APB gain register.
// Each sample runs difference, magnitude, gain multiply, divide and snap multiply; the first
// sample after reset goes straight out, and a snap weight of one skips the divide and the
// second multiply. One item at a time: a new sample is taken only in the idle state.
// Reset: synchronous; clears the primed flag, the smoothed value and sets gain to 1.0.
// Depends on asns_pkg, asns_mul and asns_div.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_snap_smoother_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [asns_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [asns_pkg::DATA_W-1:0]       pwdata,
  output logic      [asns_pkg::DATA_W-1:0]       prdata,
  output logic                                   pready,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [asns_pkg::SAMPLE_W-1:0]     s_tdata,   // [31:0] sample
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [asns_pkg::SAMPLE_W-1:0]     m_tdata    // [31:0] smoothed
);

  asns_pkg::state_t                  state;
  logic [asns_pkg::GAIN_W-1:0]       snap_gain;
  logic                              primed;
  logic [asns_pkg::SAMPLE_W-1:0]     smooth_value;
  logic [asns_pkg::SAMPLE_W-1:0]     sample;
  logic [asns_pkg::MAG_W-1:0]        diff;
  logic [asns_pkg::MAG_W-1:0]        mag;
  logic [asns_pkg::MAG_W-1:0]        mag_next;
  logic                              neg;
  logic [asns_pkg::MAG_W-1:0]        step;
  logic [asns_pkg::MAG_W-1:0]        step_round;
  logic [asns_pkg::SAMPLE_W-1:0]     smooth_next;
  logic                              snap_one;
  logic                              snap_one_path;
  logic [asns_pkg::SAMPLE_W-1:0]     smooth_next_sel;

  logic                              mul_start;
  logic                              mul_done;
  logic                              div_start;
  logic                              div_done;
  logic [asns_pkg::MAG_W-1:0]        mul_a;
  logic [asns_pkg::SNAP_W-1:0]       mul_b;
  logic [asns_pkg::PROD_W-1:0]       mul_prod;
  logic [asns_pkg::DIV_W-1:0]        div_num;
  logic [asns_pkg::DIV_W-1:0]        div_den;
  logic [asns_pkg::SNAP_W-1:0]       div_quot;

  logic                              cfg_write;
  logic                              out_free;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite
                   && (paddr[asns_pkg::ADDR_W-1:2] == asns_pkg::REG_SNAP_GAIN);
  assign prdata    = (paddr[asns_pkg::ADDR_W-1:2] == asns_pkg::REG_SNAP_GAIN)
                   ? {{(asns_pkg::DATA_W-asns_pkg::GAIN_W){1'b0}}, snap_gain} : '0;

  assign s_tready  = (state == asns_pkg::ST_IDLE) && !rst;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    mag_next    = diff[asns_pkg::MAG_W-1] ? (~diff + 1'b1) : diff;
    snap_one    = |mul_prod[asns_pkg::PROD_W-1:asns_pkg::ONE_POS];
    step_round  = mul_prod[asns_pkg::PROD_W-1:asns_pkg::SNAP_W]
                + asns_pkg::MAG_W'(mul_prod[asns_pkg::SNAP_W-1]);
    smooth_next = neg ? smooth_value - step[asns_pkg::SAMPLE_W-1:0]
                      : smooth_value + step[asns_pkg::SAMPLE_W-1:0];
    div_num     = {mul_prod[asns_pkg::ONE_POS-1:0], 1'b0};
    div_den     = {1'b1, mul_prod[asns_pkg::ONE_POS-1:0]};
    mul_start   = (state == asns_pkg::ST_ABS)
               || ((state == asns_pkg::ST_DIV) && div_done);
    div_start   = (state == asns_pkg::ST_MULG) && mul_done && !snap_one;
    if (state == asns_pkg::ST_ABS) begin
      mul_a = mag_next;
      mul_b = snap_gain;
    end else begin
      mul_a = mag;
      mul_b = div_quot;
    end
  end

  asns_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  asns_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_hi (div_num),
    .den    (div_den),
    .done   (div_done),
    .quot   (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_gain <= asns_pkg::GAIN_RESET;
    end else if (cfg_write) begin
      snap_gain <= pwdata[asns_pkg::GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= asns_pkg::ST_IDLE;
      primed       <= 1'b0;
      smooth_value <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (state == asns_pkg::ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        asns_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            if (!primed) begin
              primed       <= 1'b1;
              smooth_value <= s_tdata;
              state        <= asns_pkg::ST_OUT;
            end else begin
              state <= asns_pkg::ST_DIFF;
            end
          end
        end
        asns_pkg::ST_DIFF: state <= asns_pkg::ST_ABS;
        asns_pkg::ST_ABS:  state <= asns_pkg::ST_MULG;
        asns_pkg::ST_MULG: begin
          if (mul_done) begin
            state <= snap_one ? asns_pkg::ST_MULS : asns_pkg::ST_DIV;
          end
        end
        asns_pkg::ST_DIV: begin
          if (div_done) begin
            state <= asns_pkg::ST_MULS;
          end
        end
        asns_pkg::ST_MULS: begin
          if (snap_one_path || mul_done) begin
            smooth_value <= smooth_next_sel;
            state        <= asns_pkg::ST_OUT;
          end
        end
        asns_pkg::ST_OUT: begin
          if (out_free) begin
            state <= asns_pkg::ST_IDLE;
          end
        end
        default: state <= asns_pkg::ST_IDLE;
      endcase
    end
  end

  // Snap weight of one: the step is the whole magnitude, no second multiply.
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_one_path <= 1'b0;
    end else if (state == asns_pkg::ST_MULG && mul_done) begin
      snap_one_path <= snap_one;
    end else if (state == asns_pkg::ST_MULS) begin
      snap_one_path <= 1'b0;
    end
  end

  always_comb begin
    smooth_next_sel = smooth_next;
    if (!snap_one_path) begin
      smooth_next_sel = neg ? smooth_value - step_round[asns_pkg::SAMPLE_W-1:0]
                            : smooth_value + step_round[asns_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == asns_pkg::ST_IDLE && s_tvalid) begin
      sample <= s_tdata;
    end
    if (state == asns_pkg::ST_DIFF) begin
      diff <= {sample[asns_pkg::SAMPLE_W-1], sample}
            - {smooth_value[asns_pkg::SAMPLE_W-1], smooth_value};
    end
    if (state == asns_pkg::ST_ABS) begin
      mag <= mag_next;
      neg <= diff[asns_pkg::MAG_W-1];
    end
    if (state == asns_pkg::ST_MULG && mul_done) begin
      step <= mag;
    end
    if (state == asns_pkg::ST_OUT && out_free) begin
      m_tdata <= smooth_value;
    end
  end

endmodule
`default_nettype wire
